@@ hw/rtl/crc32_frame_checker_macros.svh @@
// ----------------------------------------------------------------------------
// crc32 frame checker assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CRC32_FRAME_CHECKER_MACROS_SVH
`define CRC32_FRAME_CHECKER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CRCFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CRCFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/crcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfc_pkg
// types, constants and the byte-wide crc-32 update for the frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package crcfc_pkg;

    // frame layout
    localparam int HEADER_LENGTH = 6;
    localparam int CRC_BYTES     = 4;
    localparam int COUNT_BITS    = 17;

    // field widths
    localparam int BYTE_BITS   = 8;
    localparam int STATUS_BITS = 3;
    localparam int LENGTH_BITS = 16;
    localparam int CRC_BITS    = 32;

    // configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // reflected ieee polynomial
    localparam logic [CRC_BITS-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_BITS-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [BYTE_BITS-1:0] byte_t;

    // verdict codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_LENGTH  = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_CRC     = 3'd4
    } status_t;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MAGIC_FIRST      = 2'd0,
        REG_MAGIC_SECOND     = 2'd1,
        REG_PROTOCOL_VERSION = 2'd2,
        REG_PAYLOAD_LIMIT    = 2'd3
    } reg_index_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [CRC_BITS-1:0] crc_update(
        input logic [CRC_BITS-1:0] crc_in,
        input byte_t               data
    );
        logic [CRC_BITS-1:0] c;
        c = crc_in ^ {{(CRC_BITS-BYTE_BITS){1'b0}}, data};
        for (int k = 0; k < BYTE_BITS; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crcfc_in_if.sv @@
// ----------------------------------------------------------------------------
// crcfc_in_if
// frame byte channel: one frame byte and its end flag per word
// ----------------------------------------------------------------------------
`default_nettype none

interface crcfc_in_if;
    logic                           valid;
    logic                           ready;
    logic [crcfc_pkg::BYTE_BITS-1:0] data_byte;
    logic                           frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crcfc_out_if.sv @@
// ----------------------------------------------------------------------------
// crcfc_out_if
// verdict channel: one frame verdict per word
// ----------------------------------------------------------------------------
`default_nettype none

interface crcfc_out_if;
    logic                              valid;
    logic                              ready;
    logic [crcfc_pkg::STATUS_BITS-1:0] status;
    logic [crcfc_pkg::BYTE_BITS-1:0]   message_type;
    logic [crcfc_pkg::LENGTH_BITS-1:0] payload_length;
    logic [crcfc_pkg::CRC_BITS-1:0]    computed_crc;

    modport source (output valid, output status, output message_type,
                    output payload_length, output computed_crc, input ready);
    modport sink   (input valid, input status, input message_type,
                    input payload_length, input computed_crc, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crc32_frame_checker.sv @@
// Checks length-prefixed request frames that arrive one byte per word, the last
// byte flagged by frame_end. A frame is six header bytes (two magic bytes,
// version, message type, 16-bit big-endian payload length), the payload and a
// big-endian ieee crc-32 over header and payload. One byte is taken every
// clock unless the input stalls; the byte passes an input register, the crc
// update and header checks run on the byte held there, and the verdict of a
// frame is loaded into an output register when its last byte leaves the input
// register. The input stalls only when a last byte is waiting and the
// previous verdict has not yet been taken.
// Magic bytes, version and payload limit are written through the apb port
// at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
// crc32_frame_checker
// frame header check, length check and crc-32 check with one verdict per frame
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_frame_checker_macros.svh"

module crc32_frame_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    crcfc_in_if.sink                               frame_in,
    crcfc_out_if.source                            verdict_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [crcfc_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [crcfc_pkg::DATA_BITS-1:0]   pwdata,
    output logic      [crcfc_pkg::DATA_BITS-1:0]   prdata,
    output logic                                   pready
);
    import crcfc_pkg::*;

    // configuration registers
    byte_t                  magic_first_reg;
    byte_t                  magic_second_reg;
    byte_t                  protocol_version_reg;
    logic [LENGTH_BITS-1:0] payload_limit_reg;
    logic                   cfg_write;
    reg_index_t             cfg_index;

    // input register
    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_end_reg;
    logic  s1_adv;
    logic  out_load_ok;

    // frame state
    logic [COUNT_BITS-1:0] byte_count_reg;
    logic [COUNT_BITS-1:0] byte_count_next;
    byte_t                 header_reg  [HEADER_LENGTH];
    byte_t                 header_next [HEADER_LENGTH];
    logic [CRC_BITS-1:0]   crc_reg;
    logic [CRC_BITS-1:0]   crc_next;
    logic [CRC_BITS-1:0]   rx_crc_reg;
    logic [CRC_BITS-1:0]   rx_crc_next;

    // verdict logic
    logic [LENGTH_BITS-1:0] decl_len;
    logic [COUNT_BITS-1:0]  crc_span;
    logic                   in_span;
    logic [LENGTH_BITS-1:0] plen;
    logic [COUNT_BITS-1:0]  frame_len;
    logic [CRC_BITS-1:0]    crc_final;
    status_t                status_next;
    logic [CRC_BITS-1:0]    crc_out_next;

    // output register
    logic                   out_valid_reg;
    status_t                out_status_reg;
    byte_t                  out_type_reg;
    logic [LENGTH_BITS-1:0] out_len_reg;
    logic [CRC_BITS-1:0]    out_crc_reg;

    // apb decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_index)
            REG_MAGIC_FIRST:      prdata = {{(DATA_BITS-BYTE_BITS){1'b0}}, magic_first_reg};
            REG_MAGIC_SECOND:     prdata = {{(DATA_BITS-BYTE_BITS){1'b0}}, magic_second_reg};
            REG_PROTOCOL_VERSION: prdata = {{(DATA_BITS-BYTE_BITS){1'b0}},
                                            protocol_version_reg};
            REG_PAYLOAD_LIMIT:    prdata = {{(DATA_BITS-LENGTH_BITS){1'b0}},
                                            payload_limit_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg      <= '0;
            magic_second_reg     <= '0;
            protocol_version_reg <= 8'd1;
            payload_limit_reg    <= 16'd4096;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAGIC_FIRST:      magic_first_reg      <= pwdata[BYTE_BITS-1:0];
                REG_MAGIC_SECOND:     magic_second_reg     <= pwdata[BYTE_BITS-1:0];
                REG_PROTOCOL_VERSION: protocol_version_reg <= pwdata[BYTE_BITS-1:0];
                REG_PAYLOAD_LIMIT:    payload_limit_reg    <= pwdata[LENGTH_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // handshake: only a last byte waits on the output register
    assign out_load_ok    = !out_valid_reg || verdict_out.ready;
    assign s1_adv         = s1_valid_reg && (!s1_end_reg || out_load_ok);
    assign frame_in.ready = !s1_valid_reg || s1_adv;

    // byte position decides header, crc span or received crc
    always_comb
    begin
        decl_len = {header_reg[4], header_reg[5]};
        crc_span = COUNT_BITS'(HEADER_LENGTH) + COUNT_BITS'(decl_len);
        in_span  = byte_count_reg < crc_span;

        crc_next    = in_span ? crc_update(crc_reg, s1_byte_reg) : crc_reg;
        rx_crc_next = in_span ? rx_crc_reg : {rx_crc_reg[CRC_BITS-BYTE_BITS-1:0], s1_byte_reg};

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 1'b1;

        for (int i = 0; i < HEADER_LENGTH; i++)
        begin
            header_next[i] = (byte_count_reg == COUNT_BITS'(i)) ? s1_byte_reg
                                                                : header_reg[i];
        end
    end

    // verdict in priority order
    always_comb
    begin
        plen         = {header_next[4], header_next[5]};
        frame_len    = COUNT_BITS'(HEADER_LENGTH) + COUNT_BITS'(plen)
                     + COUNT_BITS'(CRC_BYTES);
        crc_final    = ~crc_next;
        crc_out_next = '0;
        if (byte_count_next < COUNT_BITS'(HEADER_LENGTH + CRC_BYTES))
            status_next = ST_BAD_LENGTH;
        else if (header_next[0] != magic_first_reg || header_next[1] != magic_second_reg)
            status_next = ST_BAD_MAGIC;
        else if (header_next[2] != protocol_version_reg)
            status_next = ST_BAD_VERSION;
        else if (plen > payload_limit_reg)
            status_next = ST_BAD_LENGTH;
        else if (byte_count_next != frame_len)
            status_next = ST_BAD_LENGTH;
        else
        begin
            crc_out_next = crc_final;
            status_next  = (crc_final == rx_crc_next) ? ST_OK : ST_BAD_CRC;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (frame_in.ready)
            s1_valid_reg <= frame_in.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            s1_byte_reg <= frame_in.data_byte;
            s1_end_reg  <= frame_in.frame_end;
        end
    end

    // frame state, cleared after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= '0;
            for (int i = 0; i < HEADER_LENGTH; i++)
            begin
                header_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            if (s1_end_reg)
            begin
                byte_count_reg <= '0;
                crc_reg        <= CRC_INIT;
                rx_crc_reg     <= '0;
                for (int i = 0; i < HEADER_LENGTH; i++)
                begin
                    header_reg[i] <= '0;
                end
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                rx_crc_reg     <= rx_crc_next;
                for (int i = 0; i < HEADER_LENGTH; i++)
                begin
                    header_reg[i] <= header_next[i];
                end
            end
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_end_reg)
            out_valid_reg <= 1'b1;
        else if (verdict_out.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_end_reg)
        begin
            out_status_reg <= status_next;
            out_type_reg   <= header_next[3];
            out_len_reg    <= plen;
            out_crc_reg    <= crc_out_next;
        end
    end

    assign verdict_out.valid          = out_valid_reg;
    assign verdict_out.status         = out_status_reg;
    assign verdict_out.message_type   = out_type_reg;
    assign verdict_out.payload_length = out_len_reg;
    assign verdict_out.computed_crc   = out_crc_reg;

    // checks on the pipeline and frame state
    `CRCFC_ASSERT_SAME(a_mid_byte_never_stalls, s1_valid_reg && !s1_end_reg, s1_adv,
        "frame byte held in input register without a pending verdict")
    `CRCFC_ASSERT_NEXT(a_frame_end_clears, s1_adv && s1_end_reg,
        byte_count_reg == '0 && crc_reg == CRC_INIT,
        "frame state not cleared after last byte")
    `CRCFC_ASSERT_NEXT(a_frame_end_gives_verdict, s1_adv && s1_end_reg, out_valid_reg,
        "last byte did not load a verdict")
    `CRCFC_ASSERT_SAME(a_early_verdict_no_crc,
        out_valid_reg && out_status_reg != ST_OK && out_status_reg != ST_BAD_CRC,
        out_crc_reg == '0, "early verdict carries a crc value")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// crc32 frame checker testbench
// feeds length-prefixed frames byte by byte and compares every verdict with
// a cycle-free prediction of the header, length and crc-32 checks, over
// several magic, version and payload limit settings and random back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import crcfc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 4;

    typedef struct {
        status_t                status;
        byte_t                  message_type;
        logic [LENGTH_BITS-1:0] payload_length;
        logic [CRC_BITS-1:0]    computed_crc;
    } verdict_t;

    typedef struct {
        byte_t data;
        logic  last;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    crcfc_in_if  frame_in ();
    crcfc_out_if verdict_out ();

    crc32_frame_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_in    (frame_in),
        .verdict_out (verdict_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // register copies as the block should hold them
    byte_t                  cfg_magic_first = 8'd0;
    byte_t                  cfg_magic_second = 8'd0;
    byte_t                  cfg_version = 8'd1;
    logic [LENGTH_BITS-1:0] cfg_payload_limit = 16'd4096;

    // frame state as the block should hold it
    logic [COUNT_BITS-1:0] count_seen = '0;
    byte_t                 hdr_seen [HEADER_LENGTH];
    logic [CRC_BITS-1:0]   crc_acc = CRC_INIT;
    logic [CRC_BITS-1:0]   rx_crc = '0;

    frame_word_t byte_feed [$];
    verdict_t    verdicts_due [$];
    byte_t       frame_buf [$];

    logic steady_run = 1'b0;
    int   bytes_queued = 0;
    int   frames_queued = 0;
    int   bytes_taken = 0;
    int   verdicts_seen = 0;
    int   mismatch_count = 0;
    int   settings_used = 0;
    int   hold_asked = 0;
    int   hold_given = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // reflected crc-32, one byte lsb first
    function automatic logic [CRC_BITS-1:0] crc32_byte(input logic [CRC_BITS-1:0] acc,
                                                        input byte_t b);
        logic [CRC_BITS-1:0] r;
        r = acc ^ {{(CRC_BITS-BYTE_BITS){1'b0}}, b};
        repeat (BYTE_BITS)
            r = (r >> 1) ^ (CRC_POLY & {CRC_BITS{r[0]}});
        return r;
    endfunction

    task automatic clear_frame_state();
        count_seen = '0;
        for (int k = 0; k < HEADER_LENGTH; k++)
            hdr_seen[k] = '0;
        crc_acc = CRC_INIT;
        rx_crc = '0;
    endtask

    // one accepted frame byte; a last byte yields the frame verdict
    task automatic judge_byte(input byte_t b, input logic last);
        logic [LENGTH_BITS-1:0] plen;
        logic [CRC_BITS-1:0]    crc_final;
        verdict_t               v;
        plen = {hdr_seen[4], hdr_seen[5]};
        if (count_seen < HEADER_LENGTH)
        begin
            hdr_seen[count_seen[2:0]] = b;
            crc_acc = crc32_byte(crc_acc, b);
        end
        else if (count_seen < HEADER_LENGTH + plen)
            crc_acc = crc32_byte(crc_acc, b);
        else
            rx_crc = {rx_crc[CRC_BITS-BYTE_BITS-1:0], b};
        if (count_seen != COUNT_MAX)
            count_seen = count_seen + 1'b1;
        if (last)
        begin
            plen = {hdr_seen[4], hdr_seen[5]};
            crc_final = ~crc_acc;
            v.message_type = hdr_seen[3];
            v.payload_length = plen;
            v.computed_crc = '0;
            if (count_seen < HEADER_LENGTH + CRC_BYTES)
                v.status = ST_BAD_LENGTH;
            else if (hdr_seen[0] != cfg_magic_first || hdr_seen[1] != cfg_magic_second)
                v.status = ST_BAD_MAGIC;
            else if (hdr_seen[2] != cfg_version)
                v.status = ST_BAD_VERSION;
            else if (plen > cfg_payload_limit)
                v.status = ST_BAD_LENGTH;
            else if (count_seen != HEADER_LENGTH + plen + CRC_BYTES)
                v.status = ST_BAD_LENGTH;
            else
            begin
                v.computed_crc = crc_final;
                v.status = (crc_final == rx_crc) ? ST_OK : ST_BAD_CRC;
            end
            verdicts_due.push_back(v);
            clear_frame_state();
        end
    endtask

    // byte driver, fed from the pending word queue
    always @(posedge clk)
    begin : feed_proc
        frame_word_t w;
        if (rst_n)
        begin
            if (frame_in.valid && frame_in.ready)
            begin
                judge_byte(frame_in.data_byte, frame_in.frame_end);
                bytes_taken++;
            end
            if (!frame_in.valid || frame_in.ready)
            begin
                if (byte_feed.size() > 0 && (steady_run || $urandom_range(0, 99) >= 10))
                begin
                    w = byte_feed.pop_front();
                    frame_in.valid <= 1'b1;
                    frame_in.data_byte <= w.data;
                    frame_in.frame_end <= w.last;
                end
                else
                    frame_in.valid <= 1'b0;
            end
        end
    end

    // verdict ready: random gaps, plus long holds on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            verdict_out.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_given)
        begin
            verdict_out.ready <= 1'b0;
            hold_given <= hold_given + 1;
            hold_left <= LONG_HOLD;
        end
        else if (steady_run)
            verdict_out.ready <= 1'b1;
        else
            verdict_out.ready <= ($urandom_range(0, 99) >= 10);
    end

    // verdict monitor
    always @(posedge clk)
    begin : verdict_proc
        verdict_t e;
        if (rst_n && verdict_out.valid && verdict_out.ready)
        begin
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                $error("verdict word with none expected");
                mismatch_count++;
            end
            else
            begin
                e = verdicts_due.pop_front();
                if (verdict_out.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, verdict_out.status);
                    mismatch_count++;
                end
                if (verdict_out.message_type !== e.message_type)
                begin
                    $error("message_type: expected %0h, got %0h",
                           e.message_type, verdict_out.message_type);
                    mismatch_count++;
                end
                if (verdict_out.payload_length !== e.payload_length)
                begin
                    $error("payload_length: expected %0d, got %0d",
                           e.payload_length, verdict_out.payload_length);
                    mismatch_count++;
                end
                if (verdict_out.computed_crc !== e.computed_crc)
                begin
                    $error("computed_crc: expected %08h, got %08h",
                           e.computed_crc, verdict_out.computed_crc);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (frame_in.valid && frame_in.ready)
            || (verdict_out.valid && verdict_out.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // register write: setup cycle, then access until pready
    task automatic write_reg(input reg_index_t idx, input logic [DATA_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAGIC_FIRST:      cfg_magic_first = value[BYTE_BITS-1:0];
            REG_MAGIC_SECOND:     cfg_magic_second = value[BYTE_BITS-1:0];
            REG_PROTOCOL_VERSION: cfg_version = value[BYTE_BITS-1:0];
            REG_PAYLOAD_LIMIT:    cfg_payload_limit = value[LENGTH_BITS-1:0];
            default: ;
        endcase
    endtask

    // all four registers, junk in the unused upper bits
    task automatic apply_config(input byte_t m1, input byte_t m2, input byte_t ver,
                                input logic [LENGTH_BITS-1:0] limit);
        logic [DATA_BITS-1:0] junk;
        junk = $urandom;
        write_reg(REG_MAGIC_FIRST, {junk[31:8], m1});
        junk = $urandom;
        write_reg(REG_MAGIC_SECOND, {junk[31:8], m2});
        junk = $urandom;
        write_reg(REG_PROTOCOL_VERSION, {junk[31:8], ver});
        junk = $urandom;
        write_reg(REG_PAYLOAD_LIMIT, {junk[31:16], limit});
        settings_used++;
        @(negedge clk);
    endtask

    // hold the sender until every verdict is back and the pipe is empty
    task automatic wait_drained();
        @(negedge clk);
        while (byte_feed.size() != 0 || frame_in.valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic post_frame();
        frame_word_t w;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            w.data = frame_buf[i];
            w.last = (i == frame_buf.size() - 1);
            byte_feed.push_back(w);
        end
        bytes_queued += frame_buf.size();
        frames_queued++;
    endtask

    // header, n payload bytes, big-endian crc with optional corruption
    task automatic queue_frame(input byte_t m1, input byte_t m2, input byte_t ver,
                               input byte_t mtype, input logic [LENGTH_BITS-1:0] plen,
                               input int n, input logic [CRC_BITS-1:0] crc_flip);
        logic [CRC_BITS-1:0] acc;
        frame_buf = {};
        frame_buf.push_back(m1);
        frame_buf.push_back(m2);
        frame_buf.push_back(ver);
        frame_buf.push_back(mtype);
        frame_buf.push_back(plen[15:8]);
        frame_buf.push_back(plen[7:0]);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(byte_t'($urandom));
        acc = CRC_INIT;
        foreach (frame_buf[i])
            acc = crc32_byte(acc, frame_buf[i]);
        acc = ~acc ^ crc_flip;
        frame_buf.push_back(acc[31:24]);
        frame_buf.push_back(acc[23:16]);
        frame_buf.push_back(acc[15:8]);
        frame_buf.push_back(acc[7:0]);
        post_frame();
    endtask

    task automatic queue_noise(input int count);
        frame_buf = {};
        repeat (count)
            frame_buf.push_back(byte_t'($urandom));
        post_frame();
    endtask

    // mostly well-formed frames under the current settings, some broken ones
    task automatic random_frame();
        byte_t                  m1, m2, ver, mt;
        logic [LENGTH_BITS-1:0] plen;
        int                     cap, kind, n;
        m1 = cfg_magic_first;
        m2 = cfg_magic_second;
        ver = cfg_version;
        mt = byte_t'($urandom);
        cap = (int'(cfg_payload_limit) < 12) ? int'(cfg_payload_limit) : 12;
        if ($urandom_range(0, 19) == 0)
            cap = (int'(cfg_payload_limit) < 200) ? int'(cfg_payload_limit) : 200;
        plen = LENGTH_BITS'($urandom_range(0, cap));
        n = int'(plen);
        kind = $urandom_range(0, 99);
        if (kind < 55)
            queue_frame(m1, m2, ver, mt, plen, n, '0);
        else if (kind < 67)
            queue_frame(m1, m2, ver, mt, plen, n, $urandom | 32'h1);
        else if (kind < 72)
            queue_frame(m1 ^ byte_t'($urandom_range(1, 255)), m2, ver, mt, plen, n, '0);
        else if (kind < 77)
            queue_frame(m1, m2 ^ byte_t'($urandom_range(1, 255)), ver, mt, plen, n, '0);
        else if (kind < 82)
            queue_frame(m1, m2, ver ^ byte_t'($urandom_range(1, 255)), mt, plen, n, '0);
        else if (kind < 87 && cfg_payload_limit != 16'hFFFF)
        begin
            plen = LENGTH_BITS'($urandom_range(int'(cfg_payload_limit) + 1, 65535));
            queue_frame(m1, m2, ver, mt, plen, $urandom_range(0, 6), '0);
        end
        else if (kind < 94)
        begin
            if (plen > 0 && $urandom_range(0, 1) == 1)
                n = $urandom_range(0, int'(plen) - 1);
            else
                n = int'(plen) + $urandom_range(1, 3);
            queue_frame(m1, m2, ver, mt, plen, n, '0);
        end
        else if (kind < 97)
            queue_noise($urandom_range(1, HEADER_LENGTH + CRC_BYTES - 1));
        else
            queue_noise($urandom_range(1, 24));
    endtask

    task automatic random_phase(input int min_bytes);
        int first_bytes, first_frames;
        first_bytes = bytes_queued;
        first_frames = frames_queued;
        while (bytes_queued - first_bytes < min_bytes || frames_queued - first_frames < 6)
            random_frame();
    endtask

    // stimulus
    initial
    begin
        frame_in.valid = 1'b0;
        frame_in.data_byte = '0;
        frame_in.frame_end = 1'b0;
        verdict_out.ready = 1'b0;
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: short frames, each verdict code, length edges
        queue_noise(1);
        queue_noise(5);
        queue_noise(HEADER_LENGTH + CRC_BYTES - 1);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h00, 16'd0, 0, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'hFF, 16'd3, 3, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h5C, 16'd2, 2, 32'h8000_0000);
        queue_frame(8'h01, 8'h00, 8'h01, 8'h11, 16'd1, 1, '0);
        queue_frame(8'h00, 8'h80, 8'h01, 8'h22, 16'd1, 1, '0);
        queue_frame(8'h00, 8'h00, 8'hFE, 8'h33, 16'd1, 1, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h44, 16'd4097, 0, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h55, 16'hFFFF, 2, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h66, 16'd2, 3, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h77, 16'd3, 2, '0);
        queue_frame(8'h00, 8'h00, 8'h01, 8'h88, 16'd4096, 0, '0);
        wait_drained();

        // all-ones header bytes, zero payload limit
        apply_config(8'hFF, 8'hFF, 8'hFF, 16'd0);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hA0, 16'd0, 0, '0);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hA1, 16'd1, 1, '0);
        random_phase(100);
        wait_drained();

        // receiver held off while frames keep coming
        apply_config(8'hA5, 8'h5A, 8'h02, 16'd64);
        hold_asked++;
        random_phase(130);
        wait_drained();

        // largest payload limit, declared length at the top of range, no gaps
        apply_config(8'h00, 8'h00, 8'h00, 16'hFFFF);
        steady_run = 1'b1;
        queue_frame(8'h00, 8'h00, 8'h00, 8'hC3, 16'hFFFF, 2, '0);
        queue_frame(8'h00, 8'h00, 8'h00, 8'h3C, 16'd40, 40, '0);
        random_phase(100);
        wait_drained();
        steady_run = 1'b0;

        // random settings
        apply_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                     LENGTH_BITS'($urandom_range(16, 4096)));
        random_phase(120);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("covered %0d frame bytes and %0d verdicts under %0d register settings",
                 bytes_taken, verdicts_seen, settings_used + 1);
        $display("settings included payload limits 0 and 65535 and a long receiver hold");
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/crcfc_pkg.sv
hw/rtl/crcfc_in_if.sv
hw/rtl/crcfc_out_if.sv
hw/rtl/crc32_frame_checker.sv
test/tb.sv
